// ===== src/scfl_pkg.sv =====
// shared types, field widths, operation and status codes for the size-class allocator
package scfl_pkg;

    localparam int POOL_WORDS_DEF = 4096;
    localparam int MAX_CHUNK_DEF  = 15;

    localparam int HANDLE_W = 12;
    localparam int SIZE_W   = 5;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_REQUEST = 2'd0;
    localparam logic [OP_W-1:0] OP_RECYCLE = 2'd1;
    localparam logic [OP_W-1:0] OP_CHECK   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BIG   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_SPACE = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [SIZE_W-1:0]   chunk_size;
        logic [HANDLE_W-1:0] handle;
    } t_in_word;

    typedef struct packed {
        logic [HANDLE_W-1:0] result_handle;
        logic [STATUS_W-1:0] status;
        logic                reused;
        logic                handle_valid;
    } t_out_word;

endpackage

// ===== src/size_class_free_list_allocator.sv =====
// top level of the size-class free-list allocator
//
//  channel | direction | handshake              | word
//  --------+-----------+------------------------+---------------------
//  in      | to block  | i_in_valid / o_in_stall  | scfl_pkg::t_in_word
//  out     | from block| o_out_valid / i_out_stall| scfl_pkg::t_out_word
//
// check, no-op and size errors finish on acceptance; recycle and a request served
// from the bump pointer take one head ram read; a request popped from a free list
// takes two dependent reads, list head ram then link ram
// reset is synchronous and active low; it empties every list through valid bits
// on the head ram and sets the bump pointer to 1, with no clearing pass
// the link ram is not cleared: a link is always written before it is read
// one word is worked on at a time; the result sits in the output register, so the
// next word is taken while a result waits; a result that finds the output still
// stalled is parked and the block holds off input until it moves out
module size_class_free_list_allocator #(
    parameter int POOL_WORDS = scfl_pkg::POOL_WORDS_DEF,
    parameter int MAX_CHUNK  = scfl_pkg::MAX_CHUNK_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  scfl_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output scfl_pkg::t_out_word o_out_word
);

    // head ram: one entry per size class, index 0 unused
    localparam int HD = MAX_CHUNK + 1;
    localparam int HW = $clog2(HD);
    // link ram address
    localparam int AW = $clog2(POOL_WORDS);
    // bump pointer holds up to POOL_WORDS, the sum with a size a little more
    localparam int BW = $clog2(POOL_WORDS + MAX_CHUNK + 1);
    // common compare width for handles against pool limits
    localparam int CW = (BW > scfl_pkg::HANDLE_W) ? BW : scfl_pkg::HANDLE_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HEAD,
        S_LINK,
        S_OUT
    } t_state;

    t_state                            r_state, n_state;
    logic [scfl_pkg::OP_W-1:0]         r_op;
    logic [scfl_pkg::SIZE_W-1:0]       r_sz;
    logic [scfl_pkg::HANDLE_W-1:0]     r_h, n_h;
    logic [BW-1:0]                     r_bump, n_bump;
    logic [HD-1:0]                     r_head_vld;
    logic                              r_out_valid;
    scfl_pkg::t_out_word               r_out_word;
    scfl_pkg::t_out_word               r_res, n_res;
    logic                              n_fin;

    logic                              accept;
    logic                              out_free;
    logic [HW-1:0]                     sz_idx;
    logic [scfl_pkg::STATUS_W-1:0]     in_size_st;
    logic [scfl_pkg::HANDLE_W-1:0]     head;
    logic [BW-1:0]                     bump_sum;

    // head ram ports
    logic                              hd_we;
    logic [HW-1:0]                     hd_raddr;
    logic [scfl_pkg::HANDLE_W-1:0]     hd_rdata;

    // link ram ports
    logic                              lk_we;
    logic [AW-1:0]                     lk_waddr;
    logic [AW-1:0]                     lk_raddr;
    logic [scfl_pkg::HANDLE_W-1:0]     lk_rdata;

    function automatic logic [scfl_pkg::STATUS_W-1:0] size_status(
        input logic [scfl_pkg::SIZE_W-1:0] sz
    );
        if (sz == '0) begin
            return scfl_pkg::ST_ZERO;
        end
        if (int'(sz) > MAX_CHUNK) begin
            return scfl_pkg::ST_BIG;
        end
        return scfl_pkg::ST_OK;
    endfunction

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign sz_idx     = HW'(r_sz);
    assign in_size_st = size_status(i_in_word.chunk_size);
    assign hd_raddr   = HW'(i_in_word.chunk_size);

    // an entry never written reads as an empty list
    assign head     = r_head_vld[sz_idx] ? hd_rdata : '0;
    assign bump_sum = r_bump + BW'(r_sz);
    assign lk_raddr = AW'(head);

    scfl_ram #(
        .WIDTH (scfl_pkg::HANDLE_W),
        .DEPTH (HD)
    ) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (hd_we),
        .i_waddr (sz_idx),
        .i_wdata (r_state == S_LINK ? lk_rdata : r_h),
        .i_raddr (hd_raddr),
        .o_rdata (hd_rdata)
    );

    scfl_ram #(
        .WIDTH (scfl_pkg::HANDLE_W),
        .DEPTH (POOL_WORDS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (lk_we),
        .i_waddr (lk_waddr),
        .i_wdata (head),
        .i_raddr (lk_raddr),
        .o_rdata (lk_rdata)
    );

    assign lk_waddr = AW'(r_h);

    always_comb begin
        n_state = r_state;
        n_h     = r_h;
        n_bump  = r_bump;
        n_res   = '0;
        n_fin   = 1'b0;
        hd_we   = 1'b0;
        lk_we   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_h = i_in_word.handle;
                    unique case (i_in_word.op)
                        scfl_pkg::OP_REQUEST: begin
                            if (in_size_st != scfl_pkg::ST_OK) begin
                                n_fin        = 1'b1;
                                n_res.status = in_size_st;
                            end else begin
                                n_state = S_HEAD;
                            end
                        end
                        scfl_pkg::OP_RECYCLE: begin
                            if (in_size_st != scfl_pkg::ST_OK) begin
                                n_fin        = 1'b1;
                                n_res.status = in_size_st;
                            end else if (i_in_word.handle == '0 ||
                                         CW'(i_in_word.handle) >= CW'(POOL_WORDS)) begin
                                // handle outside the pool
                                n_fin        = 1'b1;
                                n_res.status = scfl_pkg::ST_SPACE;
                            end else begin
                                n_state = S_HEAD;
                            end
                        end
                        scfl_pkg::OP_CHECK: begin
                            n_fin              = 1'b1;
                            n_res.handle_valid = (i_in_word.handle != '0) &&
                                                 (CW'(i_in_word.handle) < CW'(r_bump));
                        end
                        default: begin
                            // no-op: all-zero result
                            n_fin = 1'b1;
                        end
                    endcase
                end
            end
            S_HEAD: begin
                if (r_op == scfl_pkg::OP_RECYCLE) begin
                    // push: link of the chunk takes the old head, head takes the chunk
                    lk_we = 1'b1;
                    hd_we = 1'b1;
                    n_fin = 1'b1;
                end else if (head != '0 && CW'(head) < CW'(POOL_WORDS)) begin
                    // pop: fetch the next link from the chunk's first word
                    n_h     = head;
                    n_state = S_LINK;
                end else if (CW'(bump_sum) > CW'(POOL_WORDS)) begin
                    n_fin        = 1'b1;
                    n_res.status = scfl_pkg::ST_SPACE;
                end else begin
                    n_fin               = 1'b1;
                    n_res.result_handle = scfl_pkg::HANDLE_W'(r_bump);
                    n_bump              = bump_sum;
                end
            end
            S_LINK: begin
                hd_we               = 1'b1;
                n_fin               = 1'b1;
                n_res.result_handle = r_h;
                n_res.reused        = 1'b1;
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (n_fin) begin
            n_state = out_free ? S_IDLE : S_OUT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bump      <= BW'(1);
            r_head_vld  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_bump  <= n_bump;
            r_h     <= n_h;
            if (accept) begin
                r_op <= i_in_word.op;
                r_sz <= i_in_word.chunk_size;
            end
            if (hd_we) begin
                r_head_vld[sz_idx] <= 1'b1;
            end
            // output register: direct load when free, otherwise park the result
            if (n_fin) begin
                if (out_free) begin
                    r_out_valid <= 1'b1;
                    r_out_word  <= n_res;
                end else begin
                    r_res <= n_res;
                end
            end else if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
                r_out_word  <= r_res;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ===== src/scfl_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
module scfl_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/scfl_chk.sv =====
// port-level assertion checker for the size-class allocator, with its bind
module scfl_chk #(
    parameter int MAX_CHUNK = scfl_pkg::MAX_CHUNK_DEF
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input scfl_pkg::t_in_word  i_in_word,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input scfl_pkg::t_out_word o_out_word
);

    logic in_acc;
    logic out_free;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !o_out_valid || !i_out_stall;

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled output word changed");

    // ready for input right after reset
    a_rst_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_in_stall)
        else $error("input stalled after reset");

    // a check finishes with its result shown in the following cycle when the output is free
    a_check_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_word.op == scfl_pkg::OP_CHECK && out_free
        |=> o_out_valid && !o_out_word.reused && o_out_word.result_handle == '0
            && o_out_word.status == scfl_pkg::ST_OK)
        else $error("check result missing or malformed");

    // a request of legal size needs the head ram, so input is held off next cycle
    a_req_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_word.op == scfl_pkg::OP_REQUEST && i_in_word.chunk_size != '0
            && int'(i_in_word.chunk_size) <= MAX_CHUNK
        |=> o_in_stall)
        else $error("request did not occupy the block");

    // a reused grant is always a good, nonzero handle
    a_reuse_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.reused
        |-> o_out_word.status == scfl_pkg::ST_OK && o_out_word.result_handle != '0
            && !o_out_word.handle_valid)
        else $error("reused grant malformed");

endmodule

bind size_class_free_list_allocator scfl_chk #(
    .MAX_CHUNK (MAX_CHUNK)
) u_scfl_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// self-checking bench for the size-class free-list allocator: directed and random words
module tb_top;

    // op three does nothing and still returns an all-zero word
    localparam logic [scfl_pkg::OP_W-1:0] OP_IDLE = 2'd3;

    localparam int RANDOM_WORDS = 1080;
    localparam int QUIET_LIMIT  = 3000;  // cycles with no handshake on either side
    localparam int HOLD_CYCLES  = 300;   // long output hold-off, well under the limit
    localparam int DRAIN_CYCLES = 20;

    // allocator shadow: free lists, link words and bump pointer, plus expected words
    class alloc_scoreboard;
        logic [scfl_pkg::HANDLE_W-1:0] link_mem [scfl_pkg::POOL_WORDS_DEF];
        logic [scfl_pkg::HANDLE_W-1:0] head_of [scfl_pkg::MAX_CHUNK_DEF + 1];
        logic [scfl_pkg::HANDLE_W:0]   bump;
        scfl_pkg::t_out_word           due_q[$];
        int                            mismatches;

        function new();
            foreach (link_mem[k]) link_mem[k] = '0;
            foreach (head_of[k]) head_of[k] = '0;
            bump = (scfl_pkg::HANDLE_W + 1)'(1);
            mismatches = 0;
        endfunction

        // updates the shadow and returns the word the block owes for this input
        function scfl_pkg::t_out_word note_input(scfl_pkg::t_in_word w);
            scfl_pkg::t_out_word r;
            logic [3:0] cls;
            r = '0;
            cls = w.chunk_size[3:0];
            if (w.op == scfl_pkg::OP_REQUEST || w.op == scfl_pkg::OP_RECYCLE) begin
                if (w.chunk_size == 0)
                    r.status = scfl_pkg::ST_ZERO;
                else if (int'(w.chunk_size) > scfl_pkg::MAX_CHUNK_DEF)
                    r.status = scfl_pkg::ST_BIG;
            end
            if (w.op == scfl_pkg::OP_REQUEST && r.status == scfl_pkg::ST_OK) begin
                if (head_of[cls] != 0) begin
                    r.result_handle = head_of[cls];
                    r.reused = 1'b1;
                    head_of[cls] = link_mem[head_of[cls]];
                end else if (int'(bump) + int'(w.chunk_size) > scfl_pkg::POOL_WORDS_DEF) begin
                    r.status = scfl_pkg::ST_SPACE;
                end else begin
                    r.result_handle = bump[scfl_pkg::HANDLE_W-1:0];
                    bump = bump + w.chunk_size;
                end
            end else if (w.op == scfl_pkg::OP_RECYCLE && r.status == scfl_pkg::ST_OK) begin
                if (w.handle == 0 || int'(w.handle) >= scfl_pkg::POOL_WORDS_DEF) begin
                    r.status = scfl_pkg::ST_SPACE;
                end else begin
                    link_mem[w.handle] = head_of[cls];
                    head_of[cls] = w.handle;
                end
            end else if (w.op == scfl_pkg::OP_CHECK) begin
                r.handle_valid = (w.handle >= 1) && ({1'b0, w.handle} < bump);
            end
            due_q.push_back(r);
            return r;
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(scfl_pkg::t_out_word got);
            scfl_pkg::t_out_word want;
            if (due_q.size() == 0) begin
                report($sformatf("unexpected word, handle %0d", got.result_handle));
                return;
            end
            want = due_q.pop_front();
            if (got.result_handle !== want.result_handle)
                report($sformatf("result_handle got %0d want %0d",
                                 got.result_handle, want.result_handle));
            if (got.status !== want.status)
                report($sformatf("status got %0d want %0d", got.status, want.status));
            if (got.reused !== want.reused)
                report($sformatf("reused got %0b want %0b", got.reused, want.reused));
            if (got.handle_valid !== want.handle_valid)
                report($sformatf("handle_valid got %0b want %0b",
                                 got.handle_valid, want.handle_valid));
        endtask
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    scfl_pkg::t_in_word  i_in_word;
    logic                o_out_valid;
    logic                i_out_stall;
    scfl_pkg::t_out_word o_out_word;

    alloc_scoreboard book;

    // chunks handed out and not yet given back, for well-formed recycles
    logic [scfl_pkg::HANDLE_W-1:0] live_h[$];
    logic [scfl_pkg::SIZE_W-1:0]   live_sz[$];

    // shared pacing flags: calm turns idling off, hold_req asks for a long hold-off
    logic calm;
    logic hold_req;
    int   quiet;

    size_class_free_list_allocator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic scfl_pkg::t_in_word mk(logic [scfl_pkg::OP_W-1:0] op, int sz, int h);
        scfl_pkg::t_in_word w;
        w.op = op;
        w.chunk_size = sz[scfl_pkg::SIZE_W-1:0];
        w.handle = h[scfl_pkg::HANDLE_W-1:0];
        return w;
    endfunction

    // offers one word from a falling edge, with random gaps, until it is taken
    task send_word(scfl_pkg::t_in_word w);
        scfl_pkg::t_out_word r;
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 34) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        r = book.note_input(w);
        // remember granted chunks so that later recycles give them back
        if (w.op == scfl_pkg::OP_REQUEST && r.status == scfl_pkg::ST_OK) begin
            live_h.push_back(r.result_handle);
            live_sz.push_back(w.chunk_size);
        end
    endtask

    // one random word; hungry favors large requests so the bump pointer runs out
    function automatic scfl_pkg::t_in_word pick_word(logic hungry);
        scfl_pkg::t_in_word w;
        int roll;
        int idx;
        logic [31:0] rnd;
        roll = $urandom_range(99);
        rnd = $urandom;
        if (hungry ? roll < 85 : roll < 45) begin
            w = mk(scfl_pkg::OP_REQUEST,
                   hungry ? $urandom_range(8, 15) : $urandom_range(1, 15), 0);
            w.handle = rnd[scfl_pkg::HANDLE_W-1:0];
        end else if ((hungry ? roll < 90 : roll < 70) && live_h.size() > 0) begin
            idx = $urandom_range(live_h.size() - 1);
            w = mk(scfl_pkg::OP_RECYCLE, live_sz[idx], live_h[idx]);
            live_h.delete(idx);
            live_sz.delete(idx);
        end else if (roll < 85) begin
            // checks: anywhere, around the bump pointer, or on a chunk in use
            case ($urandom_range(2))
                0: w = mk(scfl_pkg::OP_CHECK, $urandom_range(31), $urandom_range(4095));
                1: w = mk(scfl_pkg::OP_CHECK, $urandom_range(31),
                          int'(book.bump) + $urandom_range(2) - 1);
                default: w = mk(scfl_pkg::OP_CHECK, $urandom_range(31),
                                live_h.size() > 0 ? live_h[$urandom_range(live_h.size() - 1)] : 0);
            endcase
        end else begin
            // noise: any op, size and handle, including stray and double recycles
            w = rnd[$bits(scfl_pkg::t_in_word)-1:0];
        end
        return w;
    endfunction

    // output side: random stalls, none while calm, and one long hold when asked
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                for (int k = 0; k < HOLD_CYCLES; k++) begin
                    i_out_stall <= 1'b1;
                    @(negedge i_clk);
                end
            end else begin
                i_out_stall <= !calm && ($urandom_range(99) < 34);
            end
        end
    end

    // result checking at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            book.check_result(o_out_word);
    end

    // watchdog on handshakes: a hang on either side ends the run
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("timeout after %0d quiet cycles", quiet);
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        int bump_now;
        book = new();
        calm = 1'b0;
        hold_req = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_word = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // size errors on requests
        send_word(mk(scfl_pkg::OP_REQUEST, 0, 4095));
        send_word(mk(scfl_pkg::OP_REQUEST, 31, 0));
        send_word(mk(scfl_pkg::OP_REQUEST, 16, 0));
        // first bump grants, smallest and largest size
        send_word(mk(scfl_pkg::OP_REQUEST, 1, 0));
        send_word(mk(scfl_pkg::OP_REQUEST, 15, 0));
        // recycle rejects: zero size, oversize, handle zero
        send_word(mk(scfl_pkg::OP_RECYCLE, 0, 5));
        send_word(mk(scfl_pkg::OP_RECYCLE, 31, 4095));
        send_word(mk(scfl_pkg::OP_RECYCLE, 1, 0));
        // push and pop on one list
        send_word(mk(scfl_pkg::OP_RECYCLE, 1, 1));
        send_word(mk(scfl_pkg::OP_REQUEST, 1, 0));
        // top handle pushed beyond the bump pointer, then lifo order
        send_word(mk(scfl_pkg::OP_RECYCLE, 15, 4095));
        send_word(mk(scfl_pkg::OP_RECYCLE, 15, 2));
        send_word(mk(scfl_pkg::OP_REQUEST, 15, 0));
        send_word(mk(scfl_pkg::OP_REQUEST, 15, 0));
        send_word(mk(scfl_pkg::OP_REQUEST, 15, 0));
        // double recycle forms a cycle, the same chunk comes out twice
        send_word(mk(scfl_pkg::OP_RECYCLE, 1, 1));
        send_word(mk(scfl_pkg::OP_RECYCLE, 1, 1));
        send_word(mk(scfl_pkg::OP_REQUEST, 1, 0));
        send_word(mk(scfl_pkg::OP_REQUEST, 1, 0));
        // checks at both ends of the pool and around the bump pointer
        send_word(mk(scfl_pkg::OP_CHECK, 0, 0));
        send_word(mk(scfl_pkg::OP_CHECK, 31, 1));
        send_word(mk(scfl_pkg::OP_CHECK, 0, 4095));
        bump_now = int'(book.bump);
        send_word(mk(scfl_pkg::OP_CHECK, 1, bump_now - 1));
        send_word(mk(scfl_pkg::OP_CHECK, 1, bump_now));
        // idle op with every field bit set
        send_word(mk(OP_IDLE, 31, 4095));

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            calm = (n >= 300 && n < 460);
            if (n == 150)
                hold_req = 1'b1;
            send_word(pick_word(n >= 500 && n < 820));
        end
        calm = 1'b0;
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        while (book.due_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (book.due_q.size() != 0)
            book.report($sformatf("%0d expected words never came", book.due_q.size()));
        if (book.mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== size_class_free_list_allocator.f =====
src/scfl_pkg.sv
src/scfl_ram.sv
src/size_class_free_list_allocator.sv
src/scfl_chk.sv
tb/sv/tb_top.sv
